### design/b64d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, character codes and the alphabet lookup of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	localparam logic [1:0] GROUP_LAST = 2'd3;

	// Decoded bytes of one input character, most significant byte first.
	typedef struct packed {
		logic [23:0] bytes;
		logic [1:0]  nbytes;
		logic        fin;
		logic        err;
	} job_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] value;
	} sextet_t;

	function automatic logic is_skip(input logic [7:0] c);
		return (c == CHAR_PAD) || (c == CHAR_CR) || (c == CHAR_LF) || (c == CHAR_SPACE);
	endfunction

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t s;
		s.ok    = 1'b1;
		s.value = '0;
		if (c inside {[8'h41:8'h5A]}) begin
			s.value = 6'(c - 8'h41);
		end else if (c inside {[8'h61:8'h7A]}) begin
			s.value = 6'(c - 8'h61 + 8'd26);
		end else if (c inside {[8'h30:8'h39]}) begin
			s.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == CHAR_PLUS) begin
			s.value = 6'd62;
		end else if (c == CHAR_SLASH) begin
			s.value = 6'd63;
		end else begin
			s.ok = 1'b0;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

### design/b64d_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them and collects sextets; emits one request
// per character that yields bytes or ends the message.
// ----------------------------------------------------------------------------
module b64d_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   text_char,
	input  wire logic         final_char,
	input  wire logic         q_full,
	output logic              push,
	output b64d_pkg::job_t    job
);
	import b64d_pkg::*;

	logic [17:0] acc_q, acc_d;
	logic [1:0]  cnt_q, cnt_d;
	logic        err_q, err_d;
	logic        accept;
	sextet_t     sx;
	logic [23:0] bytes;
	logic [1:0]  nb;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		sx    = sextet_of(text_char);
		acc_d = acc_q;
		cnt_d = cnt_q;
		err_d = err_q;
		bytes = '0;
		nb    = 2'd0;
		if (!is_skip(text_char)) begin
			if (!sx.ok) begin
				err_d = 1'b1;
			end else if (!err_q) begin
				if (cnt_q == GROUP_LAST) begin
					bytes = {acc_q, sx.value};
					nb    = 2'd3;
					acc_d = '0;
					cnt_d = 2'd0;
				end else begin
					acc_d = {acc_q[11:0], sx.value};
					cnt_d = cnt_q + 2'd1;
				end
			end
		end
		// flush a partial group; a lone sextet is malformed
		if (final_char && !err_d) begin
			case (cnt_d)
				2'd2: begin
					bytes = {acc_d[11:4], 16'h0000};
					nb    = 2'd1;
				end
				2'd3: begin
					bytes = {acc_d[17:10], acc_d[9:2], 8'h00};
					nb    = 2'd2;
				end
				2'd1: begin
					err_d = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		job.bytes  = bytes;
		job.nbytes = nb;
		job.fin    = final_char;
		job.err    = err_d;
		push       = accept && ((nb != 2'd0) || final_char);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			err_q <= 1'b0;
		end else if (accept) begin
			if (final_char) begin
				acc_q <= '0;
				cnt_q <= '0;
				err_q <= 1'b0;
			end else begin
				acc_q <= acc_d;
				cnt_q <= cnt_d;
				err_q <= err_d;
			end
		end
	end

endmodule
`default_nettype wire

### design/b64d_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_queue
// Small FIFO of decode requests between the front and back parts.
// ----------------------------------------------------------------------------
module b64d_queue #(
	parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire b64d_pkg::job_t wdata,
	input  wire logic         pop,
	output b64d_pkg::job_t    rdata,
	output logic              full,
	output logic              empty
);
	import b64d_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

### design/b64d_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_back
// Unpacks each request into result items into an output register, one per
// cycle while that register is empty or out_ready takes it.
// ----------------------------------------------------------------------------
module b64d_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire b64d_pkg::job_t head,
	input  wire logic         q_empty,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [7:0]        data_byte,
	output logic              byte_valid,
	output logic              run_last,
	output logic              message_end,
	output logic              bad_message
);
	import b64d_pkg::*;

	logic [1:0] idx_q;
	logic [1:0] total_m1;
	logic       last;
	logic       load;
	logic       take;
	logic [7:0] sel_byte;
	logic       out_valid_q;
	logic [7:0] data_q;
	logic       bvalid_q, rlast_q, mend_q, bad_q;

	always_comb begin
		total_m1 = (head.nbytes == 2'd0) ? 2'd0 : head.nbytes - 2'd1;
		last     = (idx_q == total_m1);
		load     = !out_valid_q || out_ready;
		take     = load && !q_empty;
		pop      = take && last;
		case (idx_q)
			2'd0:    sel_byte = head.bytes[23:16];
			2'd1:    sel_byte = head.bytes[15:8];
			default: sel_byte = head.bytes[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= !q_empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q   <= (head.nbytes == 2'd0) ? 8'h00 : sel_byte;
			bvalid_q <= (head.nbytes != 2'd0);
			rlast_q  <= last;
			mend_q   <= last && head.fin;
			bad_q    <= last && head.fin && head.err;
		end
	end

	assign out_valid   = out_valid_q;
	assign data_byte   = data_q;
	assign byte_valid  = bvalid_q;
	assign run_last    = rlast_q;
	assign message_end = mend_q;
	assign bad_message = bad_q;

endmodule
`default_nettype wire

### design/base64_stream_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder: one character in, decoded bytes out.
// ----------------------------------------------------------------------------
// One character is taken per cycle while the request queue has room. Every
// fourth alphabet character yields three bytes, which leave one per cycle
// from the output register while out_ready is high, so the output side sets
// the pace of bursts: the queue (QUEUE_DEPTH requests) absorbs the three
// bytes of a completed group, for a sustained rate of one character per
// cycle while out_ready is high. '=', CR, LF and space are skipped. A bad
// character or a lone trailing sextet marks the message bad; bytes already
// decoded are still streamed, and the final result carries message_end
// with bad_message, so discard a message flagged bad. A final character
// that yields no byte produces one result with byte_valid low.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core #(
	parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] text_char,
	input  wire logic       final_char,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      data_byte,
	output logic            byte_valid,
	output logic            run_last,
	output logic            message_end,
	output logic            bad_message
);
	import b64d_pkg::*;

	job_t push_job, head_job;
	logic push, pop, q_full, q_empty;

	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_char  (text_char),
		.final_char (final_char),
		.q_full     (q_full),
		.push       (push),
		.job        (push_job)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_job),
		.pop    (pop),
		.rdata  (head_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	b64d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head_job),
		.q_empty     (q_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.data_byte   (data_byte),
		.byte_valid  (byte_valid),
		.run_last    (run_last),
		.message_end (message_end),
		.bad_message (bad_message)
	);

endmodule
`default_nettype wire
